FILE: hw/rtl/grb_pkg.sv
// Package for the grid boundary row reducer.
// Holds word types, field widths, register indexes and command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package grb_pkg;

    // Field widths
    localparam int SIDE_W  = 9;    // grid_side register
    localparam int PLANE_W = 17;   // plane_size register
    localparam int IDX_W   = 24;   // row number, column, full index
    localparam int VAL_W   = 64;
    localparam int SLOT_W  = 26;   // slot field
    localparam int CNT16_W = 16;   // per-row kept count

    // Divider sizing: widest dividend is the full index p (< 2^41),
    // widest divisor is the interior plane size (n0-2)^2 (< 2^18).
    localparam int DIV_W  = 41;
    localparam int DSR_W  = 18;
    localparam int STEP_W = 6;

    // Default for the entry slot counter width
    localparam int SLOT_BITS_DEF = 26;

    // APB address width (two registers, word spaced)
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes (paddr[2])
    localparam logic REG_GRID_SIDE  = 1'b0;
    localparam logic REG_PLANE_SIZE = 1'b1;

    // Register reset values and clamps
    localparam logic [SIDE_W-1:0]  SIDE_RST  = 9'd3;
    localparam logic [PLANE_W-1:0] PLANE_RST = 17'd9;
    localparam logic [SIDE_W-1:0]  SIDE_MIN  = 9'd3;

    // Command codes
    localparam logic CMD_ROW   = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    // Input word
    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  column;
        logic [VAL_W-1:0]  value_bits;
        logic              last_entry;
    } item_t;

    // Result word
    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    full_index;
        logic                kept;
        logic [IDX_W-1:0]    reduced_column;
        logic [VAL_W-1:0]    value_out;
        logic [SLOT_W-1:0]   slot;
        logic [CNT16_W-1:0]  row_kept_count;
        logic                row_done;
    } result_t;

    // Effective grid geometry handed from the register block
    typedef struct packed {
        logic [SIDE_W-1:0]  n0;    // side, at least 3
        logic [PLANE_W-1:0] nn;    // plane size, at least 1
        logic [SIDE_W-1:0]  w;     // interior side n0-2
        logic [DSR_W-1:0]   nnn;   // interior plane w*w
    } grid_t;

endpackage

`default_nettype wire

FILE: hw/rtl/grb_cfg_regs.sv
// APB register block for the grid boundary row reducer.
// Holds grid_side and plane_size and derives the effective geometry.
// Depends on grb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grb_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [grb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [grb_pkg::DATA_W-1:0]  pwdata,
    output logic      [grb_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output grb_pkg::grid_t                   grid
);

    logic [grb_pkg::SIDE_W-1:0]  side_reg;
    logic [grb_pkg::PLANE_W-1:0] plane_reg;
    logic [grb_pkg::DSR_W-1:0]   nnn_reg;
    logic [grb_pkg::DSR_W-1:0]   nnn_next;
    logic [grb_pkg::SIDE_W-1:0]  n0;
    logic [grb_pkg::PLANE_W-1:0] nn;
    logic [grb_pkg::SIDE_W-1:0]  w;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= grb_pkg::SIDE_RST;
            plane_reg <= grb_pkg::PLANE_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                grb_pkg::REG_GRID_SIDE:  side_reg  <= pwdata[grb_pkg::SIDE_W-1:0];
                grb_pkg::REG_PLANE_SIZE: plane_reg <= pwdata[grb_pkg::PLANE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            grb_pkg::REG_GRID_SIDE:  prdata = grb_pkg::DATA_W'(side_reg);
            grb_pkg::REG_PLANE_SIZE: prdata = grb_pkg::DATA_W'(plane_reg);
            default:                 prdata = '0;
        endcase
    end

    // Clamp: side below 3 acts as 3, plane size 0 acts as 1
    assign n0 = (side_reg < grb_pkg::SIDE_MIN) ? grb_pkg::SIDE_MIN : side_reg;
    assign nn = (plane_reg == '0) ? grb_pkg::PLANE_W'(1) : plane_reg;
    assign w  = n0 - grb_pkg::SIDE_W'(2);

    // Interior plane size, registered after the multiply
    assign nnn_next = grb_pkg::DSR_W'(w) * grb_pkg::DSR_W'(w);

    always_ff @(posedge clk)
    begin
        nnn_reg <= nnn_next;
    end

    assign grid.n0  = n0;
    assign grid.nn  = nn;
    assign grid.w   = w;
    assign grid.nnn = nnn_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/grb_divider.sv
// Shared iterative restoring divider, one quotient bit per cycle.
// Runs as many steps as the nbits input asks for.
// Depends on grb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grb_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [grb_pkg::DIV_W-1:0]   dividend,
    input  wire logic [grb_pkg::DSR_W-1:0]   divisor,
    input  wire logic [grb_pkg::STEP_W-1:0]  nbits,
    output logic                             done,
    output logic      [grb_pkg::DIV_W-1:0]   quotient,
    output logic      [grb_pkg::DSR_W-1:0]   remainder
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [grb_pkg::STEP_W-1:0]  cnt_reg;
    logic [grb_pkg::STEP_W-1:0]  cnt_next;
    logic [grb_pkg::DIV_W-1:0]   quo_reg;
    logic [grb_pkg::DIV_W-1:0]   quo_next;
    logic [grb_pkg::DSR_W-1:0]   rem_reg;
    logic [grb_pkg::DSR_W-1:0]   rem_next;
    logic [grb_pkg::DSR_W-1:0]   dsr_reg;
    logic [grb_pkg::DSR_W-1:0]   dsr_next;
    logic [grb_pkg::DSR_W:0]     part;
    logic [grb_pkg::DSR_W:0]     trial;
    logic                        fits;
    logic [grb_pkg::STEP_W-1:0]  pre_shift;

    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // One restoring step
    assign part  = {rem_reg, quo_reg[grb_pkg::DIV_W-1]};
    assign fits  = (part >= {1'b0, dsr_reg});
    assign trial = part - {1'b0, dsr_reg};

    // Align the dividend so its top significant bit enters first
    assign pre_shift = grb_pkg::STEP_W'(grb_pkg::DIV_W) - nbits;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            quo_next  = dividend << pre_shift;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - grb_pkg::STEP_W'(1);
            quo_next = {quo_reg[grb_pkg::DIV_W-2:0], fits};
            rem_next = fits ? trial[grb_pkg::DSR_W-1:0] : part[grb_pkg::DSR_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/grid_boundary_row_reducer_core.sv
// Grid boundary row reducer: top level with the item sequencer.
// Instantiates grb_cfg_regs and grb_divider; depends on grb_pkg.
//
// One word in, one word out. A row-begin word (command 0) is split into
// interior coordinates, turned into a full-grid index p and face tested;
// an entry word (command 1) has its column face tested and, when interior,
// renumbered to the interior index with the entry slot pre-incremented.
// All divisions and remainders by the grid side and plane size go through
// one restoring divider taking one bit per cycle, so latency is set by its
// step count; a row begin runs 41-bit index divides, and a word finishes
// early when a face is hit. Input is stalled from accept until the result
// is loaded into the output register; the next word can be taken while
// that result waits on result_stall.
// grid_side and plane_size are written over APB at byte addresses 0 and 4.
`timescale 1ns / 1ps
`default_nettype none

module grid_boundary_row_reducer_core #(
    parameter int SLOT_BITS = grb_pkg::SLOT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // APB configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [grb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [grb_pkg::DATA_W-1:0]  pwdata,
    output logic      [grb_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    // Input words
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire grb_pkg::item_t              item,
    // Result words
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output grb_pkg::result_t                 result
);

    localparam int SLOT_EXT_W = (SLOT_BITS > grb_pkg::SLOT_W) ? SLOT_BITS : grb_pkg::SLOT_W;
    localparam int MUL_A_W    = grb_pkg::IDX_W;
    localparam int PROD_W     = MUL_A_W + grb_pkg::DSR_W;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_PREP = 13'b0000000000010,
        ST_R1   = 13'b0000000000100,   // mm / nnn
        ST_R2   = 13'b0000000001000,   // r / w
        ST_R3   = 13'b0000000010000,   // j*n0 + i
        ST_R4   = 13'b0000000100000,   // k*nn + acc -> p
        ST_F1   = 13'b0000001000000,   // t % n0
        ST_F2   = 13'b0000010000000,   // t / nn, t % nn
        ST_F3   = 13'b0000100000000,   // (a - x) / n0
        ST_F4   = 13'b0001000000000,   // s / nn
        ST_C1   = 13'b0010000000000,   // (y-1)*w + (x-1)
        ST_C2   = 13'b0100000000000,   // (z-1)*nnn + acc
        ST_FIN  = 13'b1000000000000
    } state_t;

    grb_pkg::grid_t grid;

    state_t                          state_reg;
    state_t                          state_next;
    logic                            launched_reg;
    logic                            launched_next;
    grb_pkg::item_t                  item_reg;
    grb_pkg::item_t                  item_next;
    logic                            keep_reg;
    logic                            keep_next;
    logic [grb_pkg::IDX_W-1:0]       k_reg;
    logic [grb_pkg::IDX_W-1:0]       k_next;
    logic [grb_pkg::DIV_W-1:0]       acc_reg;
    logic [grb_pkg::DIV_W-1:0]       acc_next;
    logic [grb_pkg::DIV_W-1:0]       t_reg;
    logic [grb_pkg::DIV_W-1:0]       t_next;
    logic [grb_pkg::SIDE_W-1:0]      x_reg;
    logic [grb_pkg::SIDE_W-1:0]      x_next;
    logic [grb_pkg::PLANE_W-1:0]     y_reg;
    logic [grb_pkg::PLANE_W-1:0]     y_next;
    logic [grb_pkg::DIV_W-1:0]       qnn_reg;
    logic [grb_pkg::DIV_W-1:0]       qnn_next;
    logic [grb_pkg::DIV_W-1:0]       z_reg;
    logic [grb_pkg::DIV_W-1:0]       z_next;

    logic [SLOT_BITS-1:0]            entry_slot_reg;
    logic [SLOT_BITS-1:0]            entry_slot_next;
    logic [grb_pkg::IDX_W-1:0]       vec_slot_reg;
    logic [grb_pkg::IDX_W-1:0]       vec_slot_next;
    logic [grb_pkg::CNT16_W-1:0]     row_kept_reg;
    logic [grb_pkg::CNT16_W-1:0]     row_kept_next;

    logic                            result_valid_reg;
    logic                            result_valid_next;
    grb_pkg::result_t                result_reg;
    grb_pkg::result_t                result_next;

    // Divider hookup
    logic                            div_start;
    logic                            div_done;
    logic                            div_fin;
    logic [grb_pkg::DIV_W-1:0]       div_dividend;
    logic [grb_pkg::DSR_W-1:0]       div_divisor;
    logic [grb_pkg::STEP_W-1:0]      div_nbits;
    logic [grb_pkg::DIV_W-1:0]       div_q;
    logic [grb_pkg::DSR_W-1:0]       div_rem;

    // Multiply-add
    logic [MUL_A_W-1:0]              mul_a;
    logic [grb_pkg::DSR_W-1:0]       mul_b;
    logic [grb_pkg::DIV_W-1:0]       mul_c;
    logic [PROD_W-1:0]               mul_p;
    logic [grb_pkg::DIV_W-1:0]       mac;

    // Helpers
    logic                            accept;
    logic                            is_div_state;
    logic                            out_free;
    logic [grb_pkg::IDX_W-1:0]       mm;
    logic [grb_pkg::STEP_W-1:0]      t_bits;
    logic [grb_pkg::SIDE_W-1:0]      n0_top;
    logic [grb_pkg::PLANE_W-1:0]     y_top;
    logic [grb_pkg::SIDE_W-1:0]      x_new;
    logic [grb_pkg::PLANE_W-1:0]     a_new;
    logic [grb_pkg::PLANE_W-1:0]     y_new;
    logic [grb_pkg::DIV_W-1:0]       z_new;
    logic [SLOT_BITS-1:0]            entry_inc;
    logic [SLOT_EXT_W-1:0]           entry_ext;
    logic [grb_pkg::CNT16_W-1:0]     row_kept_inc;

    grb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .grid    (grid)
    );

    grb_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .nbits     (div_nbits),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // Zero-based row number; row 0 treated as row 1
    assign mm     = (item_reg.row_index == '0) ? '0
                  : item_reg.row_index - grb_pkg::IDX_W'(1);
    assign t_bits = (item_reg.command == grb_pkg::CMD_ROW)
                  ? grb_pkg::STEP_W'(grb_pkg::DIV_W) : grb_pkg::STEP_W'(grb_pkg::IDX_W);
    assign n0_top = grid.n0 - grb_pkg::SIDE_W'(1);
    assign y_top  = grb_pkg::PLANE_W'(grid.n0) - grb_pkg::PLANE_W'(1);

    // Divider results in the terms of the face test
    assign x_new = div_rem[grb_pkg::SIDE_W-1:0];
    assign a_new = div_rem[grb_pkg::PLANE_W-1:0];
    assign y_new = div_q[grb_pkg::PLANE_W-1:0];
    assign z_new = qnn_reg + grb_pkg::DIV_W'(div_q[grb_pkg::SIDE_W-1:0]);

    // Launch a divide once on entering a divide state, then wait for done
    assign is_div_state = (state_reg == ST_R1) || (state_reg == ST_R2)
                       || (state_reg == ST_F1) || (state_reg == ST_F2)
                       || (state_reg == ST_F3) || (state_reg == ST_F4);
    assign div_start    = is_div_state && !launched_reg;
    assign div_fin      = is_div_state && launched_reg && div_done;

    // Divider operand select
    always_comb
    begin
        div_dividend = '0;
        div_divisor  = grb_pkg::DSR_W'(1);
        div_nbits    = grb_pkg::STEP_W'(grb_pkg::DIV_W);
        unique case (state_reg)
            ST_R1:
            begin
                div_dividend = grb_pkg::DIV_W'(mm);
                div_divisor  = grid.nnn;
                div_nbits    = grb_pkg::STEP_W'(grb_pkg::IDX_W);
            end
            ST_R2:
            begin
                div_dividend = grb_pkg::DIV_W'(div_rem);
                div_divisor  = grb_pkg::DSR_W'(grid.w);
                div_nbits    = grb_pkg::STEP_W'(grb_pkg::DSR_W);
            end
            ST_F1:
            begin
                div_dividend = t_reg;
                div_divisor  = grb_pkg::DSR_W'(grid.n0);
                div_nbits    = t_bits;
            end
            ST_F2:
            begin
                div_dividend = t_reg;
                div_divisor  = grb_pkg::DSR_W'(grid.nn);
                div_nbits    = t_bits;
            end
            ST_F3:
            begin
                // a >= x is checked before this divide is entered
                div_dividend = grb_pkg::DIV_W'(a_new - grb_pkg::PLANE_W'(x_reg));
                div_divisor  = grb_pkg::DSR_W'(grid.n0);
                div_nbits    = grb_pkg::STEP_W'(grb_pkg::PLANE_W);
            end
            ST_F4:
            begin
                div_dividend = grb_pkg::DIV_W'(x_new);
                div_divisor  = grb_pkg::DSR_W'(grid.nn);
                div_nbits    = grb_pkg::STEP_W'(grb_pkg::SIDE_W);
            end
            default: ;
        endcase
    end

    // Multiply-add operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        unique case (state_reg)
            ST_R3:
            begin
                mul_a = MUL_A_W'(div_q[grb_pkg::SIDE_W-1:0]) + MUL_A_W'(1);
                mul_b = grb_pkg::DSR_W'(grid.n0);
                mul_c = grb_pkg::DIV_W'(div_rem[grb_pkg::SIDE_W-1:0])
                      + grb_pkg::DIV_W'(1);
            end
            ST_R4:
            begin
                mul_a = k_reg;
                mul_b = grb_pkg::DSR_W'(grid.nn);
                mul_c = acc_reg;
            end
            ST_C1:
            begin
                mul_a = MUL_A_W'(y_reg - grb_pkg::PLANE_W'(1));
                mul_b = grb_pkg::DSR_W'(grid.w);
                mul_c = grb_pkg::DIV_W'(x_reg - grb_pkg::SIDE_W'(1));
            end
            ST_C2:
            begin
                mul_a = z_reg[MUL_A_W-1:0] - MUL_A_W'(1);
                mul_b = grid.nnn;
                mul_c = grb_pkg::DIV_W'(acc_reg[grb_pkg::IDX_W-1:0]);
            end
            default: ;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mac   = mul_p[grb_pkg::DIV_W-1:0] + mul_c;

    // Counter helpers
    assign entry_inc    = entry_slot_reg + SLOT_BITS'(1);
    assign row_kept_inc = (row_kept_reg == '1) ? row_kept_reg
                        : row_kept_reg + grb_pkg::CNT16_W'(1);
    assign entry_ext    = keep_reg ? SLOT_EXT_W'(entry_inc) : SLOT_EXT_W'(entry_slot_reg);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        launched_next     = launched_reg;
        item_next         = item_reg;
        keep_next         = keep_reg;
        k_next            = k_reg;
        acc_next          = acc_reg;
        t_next            = t_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        qnn_next          = qnn_reg;
        z_next            = z_reg;
        entry_slot_next   = entry_slot_reg;
        vec_slot_next     = vec_slot_reg;
        row_kept_next     = row_kept_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        if (div_start)
        begin
            launched_next = 1'b1;
        end
        if (div_fin)
        begin
            launched_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = item;
                    t_next     = grb_pkg::DIV_W'(item.column);
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = (item_reg.command == grb_pkg::CMD_ROW) ? ST_R1 : ST_F1;
            end
            ST_R1:
            begin
                if (div_fin)
                begin
                    k_next     = div_q[grb_pkg::IDX_W-1:0] + grb_pkg::IDX_W'(1);
                    state_next = ST_R2;
                end
            end
            ST_R2:
            begin
                if (div_fin)
                begin
                    state_next = ST_R3;
                end
            end
            ST_R3:
            begin
                acc_next   = mac;
                state_next = ST_R4;
            end
            ST_R4:
            begin
                t_next     = mac;
                state_next = ST_F1;
            end
            ST_F1:
            begin
                if (div_fin)
                begin
                    x_next = x_new;
                    if ((x_new == '0) || (x_new == n0_top))
                    begin
                        keep_next  = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_F2;
                    end
                end
            end
            ST_F2:
            begin
                if (div_fin)
                begin
                    qnn_next = div_q;
                    // a < x gives a negative numerator, so y truncates to 0
                    if (a_new < grb_pkg::PLANE_W'(x_reg))
                    begin
                        keep_next  = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_F3;
                    end
                end
            end
            ST_F3:
            begin
                if (div_fin)
                begin
                    y_next = y_new;
                    if ((y_new == '0) || (y_new == y_top))
                    begin
                        keep_next  = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_F4;
                    end
                end
            end
            ST_F4:
            begin
                if (div_fin)
                begin
                    z_next = z_new;
                    if ((z_new == '0) || (z_new == grb_pkg::DIV_W'(n0_top)))
                    begin
                        keep_next  = 1'b0;
                        state_next = ST_FIN;
                    end
                    else if (item_reg.command == grb_pkg::CMD_ROW)
                    begin
                        keep_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        keep_next  = 1'b1;
                        state_next = ST_C1;
                    end
                end
            end
            ST_C1:
            begin
                acc_next   = mac;
                state_next = ST_C2;
            end
            ST_C2:
            begin
                acc_next   = mac;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.kind         = item_reg.command;
                    result_next.kept         = keep_reg;
                    result_next.value_out    = item_reg.value_bits;
                    if (item_reg.command == grb_pkg::CMD_ROW)
                    begin
                        result_next.full_index     = t_reg[grb_pkg::IDX_W-1:0];
                        result_next.reduced_column = '0;
                        result_next.slot           = grb_pkg::SLOT_W'(vec_slot_reg);
                        result_next.row_kept_count = '0;
                        result_next.row_done       = 1'b0;
                        row_kept_next              = '0;
                        if (keep_reg)
                        begin
                            vec_slot_next = vec_slot_reg + grb_pkg::IDX_W'(1);
                        end
                    end
                    else
                    begin
                        result_next.full_index     = '0;
                        result_next.reduced_column = keep_reg
                                                   ? acc_reg[grb_pkg::IDX_W-1:0] : '0;
                        result_next.slot           = entry_ext[grb_pkg::SLOT_W-1:0];
                        result_next.row_kept_count = keep_reg ? row_kept_inc : row_kept_reg;
                        result_next.row_done       = item_reg.last_entry;
                        if (keep_reg)
                        begin
                            entry_slot_next = entry_inc;
                            row_kept_next   = row_kept_inc;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            launched_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            entry_slot_reg   <= '0;
            vec_slot_reg     <= '0;
            row_kept_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            launched_reg     <= launched_next;
            result_valid_reg <= result_valid_next;
            entry_slot_reg   <= entry_slot_next;
            vec_slot_reg     <= vec_slot_next;
            row_kept_reg     <= row_kept_next;
        end
    end

    // Working registers and output word
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        keep_reg   <= keep_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        t_reg      <= t_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        qnn_reg    <= qnn_next;
        z_reg      <= z_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

FILE: tb/tb_grid_boundary_row_reducer_core.sv
// Self-checking testbench for grid_boundary_row_reducer_core.
// Programs the grid geometry over APB, sends row-begin and entry words under random
// idling, and checks every result word against a predictor. Depends on grb_pkg.
`timescale 1ns / 1ps

module tb_grid_boundary_row_reducer_core;

    import grb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam logic [ADDR_W-1:0] SIDE_ADDR  = {REG_GRID_SIDE, 2'b00};
    localparam logic [ADDR_W-1:0] PLANE_ADDR = {REG_PLANE_SIZE, 2'b00};

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic item_valid;
    logic item_stall;
    item_t in_word;
    logic result_valid;
    logic result_stall;
    result_t out_word;

    // Predictor copy of the geometry registers and the slot/row counters
    logic [SIDE_W-1:0]  geo_side;
    logic [PLANE_W-1:0] geo_plane;
    logic [SLOT_W-1:0]  entry_slots;
    logic [IDX_W-1:0]   vector_slots;
    logic [CNT16_W-1:0] row_kept_cnt;

    result_t expected_results[$];

    int error_count = 0;
    int idle_cycles = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int row_words = 0;
    int entry_words = 0;
    int kept_entries = 0;
    int dropped_entries = 0;
    int geometries = 1;

    grid_boundary_row_reducer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (in_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (out_word)
    );

    always #4 clk = ~clk;

    // Effective geometry: side below 3 acts as 3, plane 0 acts as 1
    function automatic longint grid_n0();
        return (geo_side < SIDE_MIN) ? longint'(SIDE_MIN) : longint'(geo_side);
    endfunction

    function automatic longint grid_nn();
        return (geo_plane == '0) ? 1 : longint'(geo_plane);
    endfunction

    // Face test; interior coordinates come back through x, y, z
    function automatic bit is_interior(input longint t, input longint n0, input longint nn,
                                       output longint x, output longint y, output longint z);
        x = t % n0;
        if (x == 0 || x == n0 - 1)
            return 1'b0;
        y = ((t % nn) - x) / n0;
        if (y == 0 || y == n0 - 1)
            return 1'b0;
        z = (t - x - y * n0) / nn;
        if (z == 0 || z == n0 - 1)
            return 1'b0;
        return 1'b1;
    endfunction

    // Expected result word for one accepted input word; advances the counters
    function automatic result_t predict_word(input item_t w);
        result_t r;
        longint n0, nn, wd, nnn, m, mm, k, rem, i, j, p, t, x, y, z, c;
        bit keep;
        n0 = grid_n0();
        nn = grid_nn();
        wd = n0 - 2;
        nnn = wd * wd;
        r = '0;
        r.value_out = w.value_bits;
        if (w.command == CMD_ROW) begin
            m = w.row_index;
            mm = (m == 0) ? 0 : m - 1;
            k = mm / nnn + 1;
            rem = mm % nnn;
            j = rem / wd + 1;
            i = rem % wd + 1;
            p = i + j * n0 + k * nn;
            keep = is_interior(p, n0, nn, x, y, z);
            r.kind = CMD_ROW;
            r.full_index = p[IDX_W-1:0];
            r.kept = keep;
            r.slot = vector_slots;
            if (keep)
                vector_slots = vector_slots + 1'b1;
            row_kept_cnt = '0;
        end
        else begin
            t = w.column;
            keep = is_interior(t, n0, nn, x, y, z);
            r.kind = CMD_ENTRY;
            if (keep) begin
                c = (x - 1) + (y - 1) * wd + (z - 1) * nnn;
                r.reduced_column = c[IDX_W-1:0];
                entry_slots = entry_slots + 1'b1;
                if (row_kept_cnt != '1)
                    row_kept_cnt = row_kept_cnt + 1'b1;
            end
            r.kept = keep;
            r.slot = entry_slots;
            r.row_kept_count = row_kept_cnt;
            r.row_done = w.last_entry;
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Fields a command does not use are filled with random bits
    function automatic item_t compose_word(input logic cmd, input logic [IDX_W-1:0] idx,
                                           input logic [VAL_W-1:0] val, input logic last);
        item_t w;
        w.command = cmd;
        w.value_bits = val;
        if (cmd == CMD_ROW) begin
            w.row_index = idx;
            w.column = $urandom;
            w.last_entry = $urandom_range(0, 1);
        end
        else begin
            w.row_index = $urandom;
            w.column = idx;
            w.last_entry = last;
        end
        return w;
    endfunction

    // Column near a row's grid point, so faces and interior both get hit
    function automatic longint near_column(input longint base, input longint n0,
                                           input longint nn);
        longint off, cube;
        cube = n0 * nn - 1;
        if (cube > 24'hFFFFFF)
            cube = 24'hFFFFFF;
        case ($urandom_range(0, 6))
            0: off = 0;
            1: off = 1;
            2: off = n0;
            3: off = nn;
            4: off = 1 + n0 + nn;
            5: return $urandom_range(0, cube);
            default: return $urandom_range(0, 24'hFFFFFF);
        endcase
        if ($urandom_range(0, 1))
            off = -off;
        return base + off;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input result_t want, input result_t got);
        check_field("kind", want.kind, got.kind);
        check_field("full_index", want.full_index, got.full_index);
        check_field("kept", want.kept, got.kept);
        check_field("reduced_column", want.reduced_column, got.reduced_column);
        check_field("value_out", want.value_out, got.value_out);
        check_field("slot", want.slot, got.slot);
        check_field("row_kept_count", want.row_kept_count, got.row_kept_count);
        check_field("row_done", want.row_done, got.row_done);
    endtask

    // Send one word with random lead-in idling; predict it on acceptance
    task automatic send_word(input item_t w, output result_t pred);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (item_stall);
        pred = predict_word(w);
        expected_results.push_back(pred);
        if (w.command == CMD_ROW)
            row_words++;
        else
            entry_words++;
    endtask

    task automatic hold_input();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == SIDE_ADDR)
            geo_side = data[SIDE_W-1:0];
        else
            geo_plane = data[PLANE_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reprogram geometry once the block is idle; upper data bits are junk
    task automatic set_geometry(input int unsigned side, input int unsigned plane);
        logic [DATA_W-1:0] d;
        hold_input();
        wait_drained();
        d = $urandom;
        d[SIDE_W-1:0] = side;
        apb_write(SIDE_ADDR, d);
        d = $urandom;
        d[PLANE_W-1:0] = plane;
        apb_write(PLANE_ADDR, d);
        apb_read(SIDE_ADDR, d);
        check_field("grid_side readback", geo_side, d);
        apb_read(PLANE_ADDR, d);
        check_field("plane_size readback", geo_plane, d);
        geometries++;
    endtask

    // Reset geometry (3, 9), starting with entries that have no row begin
    task automatic test_reset_defaults();
        result_t pred;
        send_word(compose_word(CMD_ENTRY, 24'd13, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd0, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ROW, 24'd1, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd13, rand64(), 1'b1), pred);
    endtask

    // Side 10: row number extremes, one column on each face, value patterns
    task automatic test_directed_edges();
        result_t pred;
        set_geometry(10, 100);
        send_word(compose_word(CMD_ROW, 24'd0, '0, 1'b0), pred);
        send_word(compose_word(CMD_ROW, 24'd1, '1, 1'b0), pred);
        send_word(compose_word(CMD_ROW, 24'd512, {16{4'hA}}, 1'b0), pred);
        send_word(compose_word(CMD_ROW, 24'd16387064, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ROW, 24'hFFFFFF, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ROW, 24'd5, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd111, {16{4'h5}}, 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd0, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd119, rand64(), 1'b0), pred);   // x at far face
        send_word(compose_word(CMD_ENTRY, 24'd101, rand64(), 1'b0), pred);   // y = 0
        send_word(compose_word(CMD_ENTRY, 24'd191, rand64(), 1'b0), pred);   // y at far face
        send_word(compose_word(CMD_ENTRY, 24'd11, rand64(), 1'b0), pred);    // z = 0
        send_word(compose_word(CMD_ENTRY, 24'd911, rand64(), 1'b0), pred);   // z at far face
        send_word(compose_word(CMD_ENTRY, 24'hFFFFFF, rand64(), 1'b1), pred);
    endtask

    // Small side, zero plane and a plane that is not side squared
    task automatic test_register_clamps();
        result_t pred;
        set_geometry(0, 0);
        send_word(compose_word(CMD_ROW, 24'd1, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd13, rand64(), 1'b0), pred);
        set_geometry(2, 4);
        send_word(compose_word(CMD_ROW, 24'd2, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd5, rand64(), 1'b0), pred);
        set_geometry(1, 9);
        send_word(compose_word(CMD_ENTRY, 24'd13, rand64(), 1'b1), pred);
        set_geometry(7, 50);
        send_word(compose_word(CMD_ROW, 24'd20, rand64(), 1'b0), pred);
        send_word(compose_word(CMD_ENTRY, 24'd60, rand64(), 1'b1), pred);
    endtask

    // Mostly well-formed rows with neighbor columns, plus noise and stray entries
    task automatic test_random_rows(input int send_pct, input int recv_pct, input int n_words);
        result_t pred;
        int unsigned side, plane;
        int sent, pick, n_ent;
        longint n0, nn, span, col, row_base;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        row_base = 0;
        for (int g = 0; g < 6; g++) begin
            case (g)
                0: begin side = $urandom_range(3, 12); plane = side * side; end
                1: begin side = 256; plane = 65536; end
                2: begin side = $urandom_range(13, 60); plane = side * side; end
                3: begin side = 3; plane = 9; end
                4: begin side = $urandom_range(4, 30); plane = $urandom_range(1, 1000); end
                default: begin side = 511; plane = 131071; end
            endcase
            set_geometry(side, plane);
            n0 = grid_n0();
            nn = grid_nn();
            span = (n0 - 2) * (n0 - 2) * (n0 - 2);
            if (span > 24'hFFFFFF)
                span = 24'hFFFFFF;
            sent = 0;
            while (sent < n_words / 6) begin
                pick = $urandom_range(99);
                // occasionally let every pending result come back first
                if (pick < 3) begin
                    hold_input();
                    wait_drained();
                end
                if (pick < 80) begin
                    send_word(compose_word(CMD_ROW, $urandom_range(1, span), rand64(), 1'b0),
                              pred);
                    row_base = pred.full_index;
                    n_ent = $urandom_range(0, 8);
                    sent += 1 + n_ent;
                    for (int e = 0; e < n_ent; e++) begin
                        col = near_column(row_base, n0, nn);
                        send_word(compose_word(CMD_ENTRY, col[IDX_W-1:0], rand64(),
                                               e == n_ent - 1), pred);
                    end
                end
                else if (pick < 90) begin
                    send_word(compose_word($urandom_range(0, 1), $urandom, rand64(),
                                           $urandom_range(0, 1)), pred);
                    sent++;
                end
                else begin
                    // entries that follow no row begin of their own
                    n_ent = $urandom_range(1, 3);
                    sent += n_ent;
                    for (int e = 0; e < n_ent; e++) begin
                        col = near_column(row_base, n0, nn);
                        send_word(compose_word(CMD_ENTRY, col[IDX_W-1:0], rand64(),
                                               $urandom_range(0, 1)), pred);
                    end
                end
            end
        end
    endtask

    // Receiver stall
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // Result checker
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result word, expected none, got 0x%0h",
                         $time, out_word);
            end
            else begin
                check_result(expected_results.pop_front(), out_word);
                if (out_word.kind == CMD_ENTRY) begin
                    if (out_word.kept)
                        kept_entries++;
                    else
                        dropped_entries++;
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        in_word = '0;
        result_stall = 1'b0;
        geo_side = SIDE_RST;
        geo_plane = PLANE_RST;
        entry_slots = '0;
        vector_slots = '0;
        row_kept_cnt = '0;
        send_idle_pct = 29;
        recv_idle_pct = 80;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_edges();
        test_register_clamps();
        test_random_rows(29, 80, 600);
        test_random_rows(80, 29, 600);
        test_random_rows(0, 0, 600);

        hold_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d row-begin and %0d entry words over %0d geometry settings.",
                 row_words, entry_words, geometries);
        $display("Entries kept: %0d, dropped on a face: %0d, errors: %0d.",
                 kept_entries, dropped_entries, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/grb_pkg.sv
hw/rtl/grb_cfg_regs.sv
hw/rtl/grb_divider.sv
hw/rtl/grid_boundary_row_reducer_core.sv
tb/tb_grid_boundary_row_reducer_core.sv
